// ===== rtl/sre_pkg.sv =====
// Shared types, widths and constants of the softmax row engine.
`default_nettype none

package sre_pkg;

	localparam int MAX_ROW_DEF = 64;
	localparam int CFG_W       = 7;
	localparam int SCORE_W     = 16;
	localparam int PROB_W      = 16;
	localparam int EXP_W       = 17;
	localparam int SUM_W       = 23;
	localparam int DIV_STEPS   = 17;

	localparam logic [CFG_W-1:0]   ROW_LENGTH_RST = 7'd64;
	localparam logic [SCORE_W-1:0] SCORE_MIN      = 16'h8000;
	localparam logic [16:0]        LOG2E_Q16      = 17'd94548;
	localparam logic [16:0]        ROUND_Q16      = 17'd32768;
	localparam logic [EXP_W-1:0]   EXP_ONE        = 17'h10000;
	localparam logic [8:0]         K_FLUSH        = 9'd16;
	localparam logic [PROB_W-1:0]  PROB_SAT       = 16'hFFFF;

	typedef enum logic [3:0] {
		S_IDLE,
		S_READ,
		S_DIFF,
		S_LOG,
		S_FRAC,
		S_EXP,
		S_ERD,
		S_DLOAD,
		S_DIV,
		S_EMIT
	} state_t;

	function automatic logic [15:0] frac_factor(input logic [2:0] idx);
		logic [15:0] f;
		unique case (idx)
			3'd0: f = 16'd46341;
			3'd1: f = 16'd55109;
			3'd2: f = 16'd60097;
			3'd3: f = 16'd62757;
			3'd4: f = 16'd64132;
			3'd5: f = 16'd64830;
			3'd6: f = 16'd65182;
			3'd7: f = 16'd65359;
			default: f = 16'd65359;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/softmax_row_engine.sv =====
// Row softmax engine: row store, exp pass, division pass and output register.
//
// Usage: scores (signed Q8.8) enter one per request on the in channel
// (in_valid/in_ready). After row_length scores the engine emits one
// probability (unsigned Q0.16) per score, in arrival order, on the out
// channel (out_valid/out_ready), with row_end high on the last one.
// The row_length register is written through the cfg channel; 0 acts as 1
// and values above MAX_ROW act as MAX_ROW.
// A score is taken whenever the engine is idle. On the last score of a
// row of N scores the engine runs an exp pass (per score: row memory read,
// difference, log2 scaling, eight mantissa steps, exp memory write) and
// then a division pass (per score: exp memory read, numerator load,
// 17-step restoring divider, output load).
// The next row is taken as soon as the last probability sits in the output
// register. A stalled receiver holds the divider pass at the output load.
// Reset empties the row, sets the maximum to the most negative score and
// row_length to 64; the row memory needs no clearing.
`default_nettype none

module softmax_row_engine
	import sre_pkg::*;
#(
	parameter int MAX_ROW = MAX_ROW_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_W-1:0]     row_length,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [SCORE_W-1:0] score,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [PROB_W-1:0]         probability,
	output logic                      row_end
);

	localparam int IDX_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
	localparam int CNT_W = $clog2(MAX_ROW + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]          row_length_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [SCORE_W-1:0] row_max_q;
	logic [SUM_W-1:0]          exp_sum_q;
	logic [IDX_W-1:0]          idx_q;

	logic [SCORE_W-1:0] row_mem [MAX_ROW];
	logic [EXP_W-1:0]   exp_mem [MAX_ROW];
	logic [SCORE_W-1:0] row_rdata_q;
	logic [EXP_W-1:0]   exp_rdata_q;

	logic [SCORE_W-1:0] n_q;
	logic [8:0]         k_q;
	logic [7:0]         f_q;
	logic [EXP_W-1:0]   m_q;
	logic [2:0]         bit_q;
	logic [SUM_W-1:0]   rem_q;
	logic [DIV_STEPS-1:0] dq_q;
	logic [4:0]         div_cnt_q;

	logic               out_valid_q;
	logic [PROB_W-1:0]  probability_q;
	logic               row_end_q;

	logic [CNT_W-1:0] len_eff;
	logic [CNT_W-1:0] count_inc;
	logic             row_done;
	logic             take;
	logic             last_elem;
	logic             out_load;
	logic             frac_done;
	logic             div_done;

	logic [33:0]      t_prod;
	logic [33:0]      m_prod;
	logic [EXP_W-1:0] m_next;
	logic [EXP_W-1:0] e_val;
	logic [32:0]      num;
	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   trial_sub;
	logic             trial_ge;

	always_comb begin
		if (row_length_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (row_length_q > CFG_W'(MAX_ROW)) begin
			len_eff = CNT_W'(MAX_ROW);
		end else begin
			len_eff = row_length_q[CNT_W-1:0];
		end
	end

	assign count_inc = count_q + CNT_W'(1);
	assign row_done  = count_inc >= len_eff;
	assign last_elem = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign frac_done = bit_q == 3'd7;
	assign div_done  = div_cnt_q == 5'(DIV_STEPS - 1);

	assign t_prod = 34'(n_q) * 34'(LOG2E_Q16) + 34'(ROUND_Q16);
	assign m_prod = 34'(m_q) * 34'(frac_factor(bit_q)) + 34'(ROUND_Q16);
	assign m_next = f_q[7] ? m_prod[32:16] : m_q;
	assign e_val  = (k_q > K_FLUSH) ? '0 : (m_q >> k_q[4:0]);
	assign num    = {exp_rdata_q, 16'b0} + 33'(exp_sum_q >> 1);
	assign trial     = {rem_q, dq_q[DIV_STEPS-1]};
	assign trial_ge  = trial >= {1'b0, exp_sum_q};
	assign trial_sub = trial - {1'b0, exp_sum_q};

	always_comb begin
		in_ready  = state_q == S_IDLE;
		cfg_ready = 1'b1;
		take      = in_valid && in_ready;
		out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (take && row_done) state_d = S_READ;
			S_READ:  state_d = S_DIFF;
			S_DIFF:  state_d = S_LOG;
			S_LOG:   state_d = S_FRAC;
			S_FRAC:  if (frac_done) state_d = S_EXP;
			S_EXP:   state_d = last_elem ? S_ERD : S_READ;
			S_ERD:   state_d = S_DLOAD;
			S_DLOAD: state_d = S_DIV;
			S_DIV:   if (div_done) state_d = S_EMIT;
			S_EMIT:  if (out_load) state_d = last_elem ? S_IDLE : S_ERD;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_mem[count_q[IDX_W-1:0]] <= score;
		end
		row_rdata_q <= row_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXP) begin
			exp_mem[idx_q] <= e_val;
		end
		exp_rdata_q <= exp_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			count_q      <= '0;
			row_max_q    <= SCORE_MIN;
			exp_sum_q    <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				row_length_q <= row_length;
			end
			if (take) begin
				count_q <= count_inc;
				if (score > row_max_q) begin
					row_max_q <= score;
				end
				if (row_done) begin
					exp_sum_q <= '0;
					idx_q     <= '0;
				end
			end
			if (state_q == S_EXP) begin
				exp_sum_q <= exp_sum_q + SUM_W'(e_val);
				idx_q     <= last_elem ? '0 : idx_q + IDX_W'(1);
			end
			if (out_load) begin
				if (last_elem) begin
					count_q   <= '0;
					row_max_q <= SCORE_MIN;
					idx_q     <= '0;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_DIFF: begin
				n_q <= SCORE_W'(row_max_q - $signed(row_rdata_q));
			end
			S_LOG: begin
				k_q   <= t_prod[32:24];
				f_q   <= t_prod[23:16];
				m_q   <= EXP_ONE;
				bit_q <= '0;
			end
			S_FRAC: begin
				m_q   <= m_next;
				f_q   <= {f_q[6:0], 1'b0};
				bit_q <= bit_q + 3'd1;
			end
			S_DLOAD: begin
				rem_q     <= SUM_W'(num[32:17]);
				dq_q      <= num[16:0];
				div_cnt_q <= '0;
			end
			S_DIV: begin
				rem_q     <= trial_ge ? trial_sub[SUM_W-1:0] : trial[SUM_W-1:0];
				dq_q      <= {dq_q[DIV_STEPS-2:0], trial_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			probability_q <= dq_q[DIV_STEPS-1] ? PROB_SAT : dq_q[PROB_W-1:0];
			row_end_q     <= last_elem;
		end
	end

	assign out_valid   = out_valid_q;
	assign probability = probability_q;
	assign row_end     = row_end_q;

	a_sum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DLOAD |-> exp_sum_q >= SUM_W'(EXP_ONE))
		else $error("exp sum below one at division start");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> dq_q <= EXP_ONE)
		else $error("quotient above one");

	a_mant_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FRAC |-> m_q <= EXP_ONE)
		else $error("mantissa above one");

	a_count_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> count_q < CNT_W'(MAX_ROW))
		else $error("row store overrun");

	a_row_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && last_elem |=> state_q == S_IDLE && count_q == '0)
		else $error("row not closed after last result");

endmodule

`default_nettype wire

// ===== bench/softmax_row_engine_test.sv =====
// Self-checking bench for softmax_row_engine: random and directed score rows against a predictor.
`default_nettype none

module softmax_row_engine_test
	import sre_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned EXP_FACTOR [8] = '{
		46341, 55109, 60097, 62757, 64132, 64830, 65182, 65359
	};
	localparam int QUIET_LIMIT   = 6000;
	localparam int SETTLE_CYCLES = 40;
	localparam int END_CYCLES    = 850;
	localparam int RANDOM_ITEMS  = 330;

	class prob_scoreboard;
		typedef struct packed {
			logic [PROB_W-1:0] prob;
			logic              last;
		} prob_item_t;

		int unsigned                  cfg_len;
		logic signed [SCORE_W-1:0]    row_scores [MAX_ROW_DEF];
		int unsigned                  held;
		logic signed [SCORE_W-1:0]    row_max;
		prob_item_t                   expected_probs [$];
		int                           errors;

		function new();
			cfg_len = MAX_ROW_DEF;
			held    = 0;
			row_max = SCORE_MIN;
			errors  = 0;
		endfunction

		function void take_row_length(logic [CFG_W-1:0] v);
			cfg_len = 32'(v);
		endfunction

		function longint unsigned exp_of_gap(int unsigned gap);
			longint unsigned t;
			longint unsigned m;
			longint unsigned k;
			int b;
			t = (longint'(gap) * 64'd94548 + 64'd32768) >> 16;
			k = t >> 8;
			if (k > 16)
				return 0;
			m = 64'd65536;
			for (b = 0; b < 8; b++) begin
				if (t[7-b])
					m = (m * EXP_FACTOR[b] + 64'd32768) >> 16;
			end
			return m >> k;
		endfunction

		function void take_score(logic signed [SCORE_W-1:0] s);
			int unsigned len;
			int unsigned i;
			longint unsigned sum;
			longint unsigned e;
			longint unsigned p;
			prob_item_t item;
			len = cfg_len;
			if (len < 1)
				len = 1;
			if (len > MAX_ROW_DEF)
				len = MAX_ROW_DEF;
			if (held >= MAX_ROW_DEF)
				held = MAX_ROW_DEF - 1;
			row_scores[held] = s;
			if (s > row_max)
				row_max = s;
			held++;
			if (held < len)
				return;
			sum = 0;
			for (i = 0; i < held; i++)
				sum += exp_of_gap(int'(row_max) - int'(row_scores[i]));
			for (i = 0; i < held; i++) begin
				e = exp_of_gap(int'(row_max) - int'(row_scores[i]));
				p = (e * 64'd65536 + sum / 2) / sum;
				if (p > 64'd65535)
					p = 64'd65535;
				item.prob = p[PROB_W-1:0];
				item.last = (i + 1 == held);
				expected_probs.push_back(item);
			end
			held    = 0;
			row_max = SCORE_MIN;
		endfunction

		function void check_probability(logic [PROB_W-1:0] p, logic last);
			prob_item_t want;
			if (expected_probs.size() == 0) begin
				$display("%0t: probability %0d row_end %0b arrived, expected none",
					$time, p, last);
				errors++;
				return;
			end
			want = expected_probs.pop_front();
			if (p !== want.prob) begin
				$display("%0t: probability expected %0d, actual %0d", $time, want.prob, p);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: row_end expected %0b, actual %0b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [CFG_W-1:0]          row_length  = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic signed [SCORE_W-1:0] score       = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic [PROB_W-1:0]         probability;
	logic                      row_end;

	int                        send_idle   = 20;
	int                        recv_idle   = 88;
	int                        hold_cycles = 0;
	int                        quiet_cycles = 0;
	logic signed [SCORE_W-1:0] batch [$];
	prob_scoreboard            sb = new();

	softmax_row_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.row_length  (row_length),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.score       (score),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.probability (probability),
		.row_end     (row_end)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			out_ready   = 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_ready = ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_probability(probability, row_end);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_row_length(input logic [CFG_W-1:0] v);
		cfg_valid  = 1'b1;
		row_length = v;
		do @(posedge clk); while (!cfg_ready);
		sb.take_row_length(v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_score(input logic signed [SCORE_W-1:0] v);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		score    = v;
		do @(posedge clk); while (!in_ready);
		sb.take_score(v);
		@(negedge clk);
	endtask

	task automatic send_batch();
		foreach (batch[i])
			send_score(batch[i]);
		in_valid = 1'b0;
	endtask

	task automatic wait_row_drained();
		while (sb.expected_probs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		int unsigned eff;
		int unsigned n;
		int unsigned spread;
		int unsigned r;
		int          base;
		int          v;
		bit          pressed;
		sent    = 0;
		pressed = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_row_length(7'd1);
		batch = {16'sh7FFF, 16'sh8000, 16'sh0000};
		send_batch();
		wait_row_drained();

		write_row_length(7'd2);
		batch = {16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0100, 16'sh0000,
			16'sh0000, -16'sd3010, 16'sh0000, -16'sd3020};
		send_batch();
		wait_row_drained();

		write_row_length(7'd0);
		batch = {16'sd5};
		send_batch();
		wait_row_drained();

		// shrink the row below the held count, then grow it mid-row
		write_row_length(7'd4);
		batch = {16'sd100, -16'sd50, 16'sd300};
		send_batch();
		wait_row_drained();
		write_row_length(7'd2);
		batch = {-16'sd400};
		send_batch();
		wait_row_drained();
		write_row_length(7'd3);
		batch = {16'sd1};
		send_batch();
		wait_row_drained();
		write_row_length(7'd5);
		batch = {16'sd2, 16'sd3, 16'sd4, 16'sd5};
		send_batch();
		wait_row_drained();
		sent = 23;

		while (sent < RANDOM_ITEMS + 23) begin
			if (sent < 120) begin
				send_idle = 20;
				recv_idle = 88;
			end else if (sent < 240) begin
				send_idle = 88;
				recv_idle = 20;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			wait_row_drained();
			// hold off the receiver so the engine fills and stalls its input
			if (sent >= 240 && !pressed) begin
				pressed = 1'b1;
				write_row_length(7'd3);
				@(posedge clk);
				hold_cycles = 1500;
				@(negedge clk);
				batch = {};
				repeat (12) batch.push_back(16'($urandom_range(65535)));
				send_batch();
				sent += 12;
				continue;
			end
			r = $urandom_range(99);
			if (r < 70)
				len = $urandom_range(1, 8);
			else if (r < 85)
				len = $urandom_range(9, 20);
			else if (r < 88)
				len = 0;
			else if (r < 93)
				len = 64;
			else if (r < 97)
				len = $urandom_range(65, 127);
			else
				len = $urandom_range(21, 63);
			eff = (len < 1) ? 1 : (len > MAX_ROW_DEF) ? MAX_ROW_DEF : len;
			write_row_length(len[CFG_W-1:0]);
			n = eff * $urandom_range(1, (eff > 16) ? 1 : 4);
			if ($urandom_range(3) == 0)
				n += $urandom_range(eff - 1);
			base   = int'($urandom_range(65535)) - 32768;
			spread = $urandom_range(1, 2048);
			repeat (n) begin
				r = $urandom_range(99);
				if (r < 12)
					v = int'($urandom_range(65535)) - 32768;
				else if (r < 20)
					v = $urandom_range(1) ? 32767 : -32768;
				else
					v = base + int'($urandom_range(2 * spread)) - int'(spread);
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				send_score(v[SCORE_W-1:0]);
			end
			in_valid = 1'b0;
			sent += n;
		end

		wait_row_drained();
		repeat (END_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.expected_probs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
